/* design/rcei_pkg.sv */
// Shared types, constants, fixed-point helpers and the sequencer program.
package rcei_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IFRAC     = 32;
  localparam int UP_SHIFT  = IFRAC - FRAC_BITS;
  localparam int MAX_HITS  = 4;
  localparam int PC_W      = 8;
  localparam int RA_W      = 6;
  localparam int RF_DEPTH  = 1 << RA_W;

  typedef logic signed [63:0] fx_t;

  localparam fx_t FX_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam fx_t FX_MIN  = 64'sh8000_0000_0000_0000;
  localparam fx_t FX_ONE  = 64'sh0000_0001_0000_0000;
  localparam fx_t FX_ZERO = 64'sh0;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } req_t;

  typedef struct packed {
    logic signed [31:0] hit_distance;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic               entering;
    logic               last_hit;
  } res_t;

  typedef enum logic [2:0] {
    CFG_AXIS_X  = 3'd0,
    CFG_AXIS_Y  = 3'd1,
    CFG_AXIS_Z  = 3'd2,
    CFG_LOWER_Z = 3'd3,
    CFG_UPPER_Z = 3'd4,
    CFG_TOL     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic        [30:0] ax;
    logic        [30:0] ay;
    logic        [30:0] az;
    logic signed [31:0] zlo;
    logic signed [31:0] zhi;
    logic        [15:0] tol;
  } cfg_t;

  typedef struct packed {
    fx_t  t;
    fx_t  x;
    fx_t  y;
    fx_t  z;
    logic ent;
  } hit_t;

  typedef struct packed {
    hit_t [MAX_HITS-1:0] h;
    logic [2:0]          n;
  } hitset_t;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SQRT, OP_SNAP,
    OP_BLE, OP_BLT, OP_BMAGLE, OP_SETGE, OP_ANDLE, OP_SETLE, OP_SETLT,
    OP_REC, OP_END
  } op_e;

  typedef enum logic [1:0] {AR_MUL, AR_DIV, AR_SQRT} ar_e;

  typedef struct packed {
    op_e             op;
    logic [RA_W-1:0] dst;
    logic [RA_W-1:0] a;
    logic [RA_W-1:0] b;
    logic [PC_W-1:0] tgt;
  } uop_t;

  // operand addresses below R_MEM0 come from constants, the ray and configuration
  localparam logic [RA_W-1:0] R_ZERO = 6'd0,  R_ONE = 6'd1,  R_TOL = 6'd2;
  localparam logic [RA_W-1:0] R_AX = 6'd3,    R_ZLO = 6'd6,  R_ZHI = 6'd7;
  localparam logic [RA_W-1:0] R_PX = 6'd8,    R_PZ = 6'd10,  R_DX = 6'd11;
  localparam logic [RA_W-1:0] R_DZ = 6'd13,   R_ONETOL = 6'd14;
  localparam logic [RA_W-1:0] R_MEM0 = 6'd16;
  localparam logic [RA_W-1:0] R_TS = 6'd16,   R_Q0 = 6'd17,  R_U0 = 6'd20;
  localparam logic [RA_W-1:0] R_V0 = 6'd23,   R_A = 6'd26,   R_B = 6'd27;
  localparam logic [RA_W-1:0] R_C = 6'd28,    R_T1 = 6'd29,  R_T2 = 6'd30;
  localparam logic [RA_W-1:0] R_S = 6'd32,    R_NB = 6'd33,  R_T = 6'd34;
  localparam logic [RA_W-1:0] R_PT0 = 6'd35,  R_PT2 = 6'd37, R_W0 = 6'd38;
  localparam logic [RA_W-1:0] R_ZLOM = 6'd41, R_ZHIP = 6'd42, R_DISC = 6'd43;

  localparam int PC_ROOT0  = 43;
  localparam int PC_ROOT1  = 65;
  localparam int PC_PLANES = 87;
  localparam int PC_PLANE0 = 88;
  localparam int PC_PLANE1 = 108;
  localparam int PC_END    = 128;

  function automatic fx_t sat65(input logic signed [64:0] s);
    if (s[64] != s[63]) return s[64] ? FX_MIN : FX_MAX;
    return s[63:0];
  endfunction

  function automatic fx_t sadd(input fx_t a, input fx_t b);
    return sat65({a[63], a} + {b[63], b});
  endfunction

  function automatic fx_t ssub(input fx_t a, input fx_t b);
    return sat65({a[63], a} - {b[63], b});
  endfunction

  function automatic logic [63:0] fmag(input fx_t a);
    return a[63] ? (~a + 64'd1) : a;
  endfunction

  function automatic fx_t from_mag(input logic neg, input logic [63:0] m);
    if (neg) return m[63] ? FX_MIN : fx_t'(~m + 64'd1);
    return m[63] ? FX_MAX : fx_t'(m);
  endfunction

  function automatic fx_t sx32(input logic signed [31:0] v);
    return {{(32-UP_SHIFT){v[31]}}, v, {UP_SHIFT{1'b0}}};
  endfunction

  function automatic fx_t axis_of(input logic [30:0] v);
    logic [30:0] vv;
    vv = (v == 31'd0) ? 31'd1 : v;
    return {{(33-UP_SHIFT){1'b0}}, vv, {UP_SHIFT{1'b0}}};
  endfunction

  function automatic fx_t tol_fx(input logic [15:0] t);
    return {{(48-UP_SHIFT){1'b0}}, t, {UP_SHIFT{1'b0}}};
  endfunction

  function automatic logic signed [31:0] to_out(input fx_t x);
    logic [63:0] m;
    m = (fmag(x) + (64'd1 << (UP_SHIFT - 1))) >> UP_SHIFT;
    if (x[63]) begin
      if (m > 64'h8000_0000) return 32'sh8000_0000;
      return 32'(~m + 64'd1);
    end
    if (m > 64'h7FFF_FFFF) return 32'sh7FFF_FFFF;
    return 32'(m);
  endfunction

  function automatic uop_t mk(input op_e op, input logic [RA_W-1:0] d,
                              input logic [RA_W-1:0] a, input logic [RA_W-1:0] b,
                              input int tgt = 0);
    uop_t u;
    u.op  = op;
    u.dst = d;
    u.a   = a;
    u.b   = b;
    u.tgt = PC_W'(tgt);
    return u;
  endfunction

  // three-term dot product through T1/T2
  function automatic uop_t dot_u(input int k, input logic [RA_W-1:0] d,
                                 input logic [RA_W-1:0] a0, input logic [RA_W-1:0] b0);
    case (k)
      0:       return mk(OP_MUL, R_T1, a0, b0);
      1:       return mk(OP_MUL, R_T2, a0 + 6'd1, b0 + 6'd1);
      2:       return mk(OP_ADD, R_T1, R_T1, R_T2);
      3:       return mk(OP_MUL, R_T2, a0 + 6'd2, b0 + 6'd2);
      default: return mk(OP_ADD, d, R_T1, R_T2);
    endcase
  endfunction

  // point = P + t*D
  function automatic uop_t point_u(input int k);
    logic [RA_W-1:0] c;
    c = RA_W'(k >> 1);
    if ((k & 1) == 0) return mk(OP_MUL, R_T2, R_T, R_DX + c);
    return mk(OP_ADD, R_PT0 + c, R_PX + c, R_T2);
  endfunction

  function automatic uop_t root_u(input int k, input logic upper);
    if (k == 0) return upper ? mk(OP_ADD, R_T1, R_NB, R_S) : mk(OP_SUB, R_T1, R_NB, R_S);
    if (k == 1) return mk(OP_DIV, R_T1, R_T1, R_A);
    if (k == 2) return mk(OP_ADD, R_T1, R_T1, R_TS);
    if (k == 3) return mk(OP_SNAP, R_T, R_T1, R_TOL);
    if (k < 10) return point_u(k - 4);
    if (k < 13) return mk(OP_DIV, R_W0 + RA_W'(k - 10), R_PT0 + RA_W'(k - 10),
                          R_AX + RA_W'(k - 10));
    if (k < 18) return dot_u(k - 13, R_T1, R_W0, R_V0);
    if (k == 18) return mk(OP_SETLT, R_ZERO, R_T1, R_ZERO);
    if (k == 19) return mk(OP_SETGE, R_ZERO, R_PT2, R_ZLOM);
    if (k == 20) return mk(OP_ANDLE, R_ZERO, R_PT2, R_ZHIP);
    return mk(OP_REC, R_ZERO, R_ZERO, R_ZERO);
  endfunction

  function automatic uop_t plane_u(input int k, input logic upper);
    if (k == 0) return mk(OP_SUB, R_T1, upper ? R_ZHI : R_ZLO, R_PZ);
    if (k == 1) return mk(OP_DIV, R_T1, R_T1, R_DZ);
    if (k == 2) return mk(OP_SNAP, R_T, R_T1, R_TOL);
    if (k < 9) return point_u(k - 3);
    if (k < 12) return mk(OP_DIV, R_W0 + RA_W'(k - 9), R_PT0 + RA_W'(k - 9),
                          R_AX + RA_W'(k - 9));
    if (k < 17) return dot_u(k - 12, R_T1, R_W0, R_W0);
    if (k == 17) return mk(OP_SETLE, R_ZERO, R_T1, R_ONETOL);
    if (k == 18) return upper ? mk(OP_SETLT, R_ZERO, R_DZ, R_ZERO)
                              : mk(OP_SETLT, R_ZERO, R_ZERO, R_DZ);
    return mk(OP_REC, R_ZERO, R_ZERO, R_ZERO);
  endfunction

  function automatic uop_t rcei_rom(input logic [PC_W-1:0] pc);
    int p;
    int k;
    p = int'(pc);
    if (p < 5) return dot_u(p, R_T1, R_PX, R_DX);
    if (p == 5) return mk(OP_SUB, R_TS, R_ZERO, R_T1);
    if (p < 12) begin
      k = p - 6;
      if ((k & 1) == 0) return mk(OP_MUL, R_T1, R_TS, R_DX + RA_W'(k >> 1));
      return mk(OP_ADD, R_Q0 + RA_W'(k >> 1), R_PX + RA_W'(k >> 1), R_T1);
    end
    if (p < 15) return mk(OP_DIV, R_U0 + RA_W'(p - 12), R_Q0 + RA_W'(p - 12),
                          R_AX + RA_W'(p - 12));
    if (p < 18) return mk(OP_DIV, R_V0 + RA_W'(p - 15), R_DX + RA_W'(p - 15),
                          R_AX + RA_W'(p - 15));
    if (p < 23) return dot_u(p - 18, R_A, R_V0, R_V0);
    if (p < 28) return dot_u(p - 23, R_B, R_U0, R_V0);
    if (p < 33) return dot_u(p - 28, R_T1, R_U0, R_U0);
    if (p == 33) return mk(OP_SUB, R_C, R_T1, R_ONE);
    if (p == 34) return mk(OP_SUB, R_ZLOM, R_ZLO, R_TOL);
    if (p == 35) return mk(OP_ADD, R_ZHIP, R_ZHI, R_TOL);
    if (p == 36) return mk(OP_BLE, R_ZERO, R_A, R_ZERO, PC_PLANES);
    if (p == 37) return mk(OP_MUL, R_T1, R_B, R_B);
    if (p == 38) return mk(OP_MUL, R_T2, R_A, R_C);
    if (p == 39) return mk(OP_SUB, R_DISC, R_T1, R_T2);
    if (p == 40) return mk(OP_BLT, R_ZERO, R_DISC, R_ZERO, PC_PLANES);
    if (p == 41) return mk(OP_SQRT, R_S, R_DISC, R_ZERO);
    if (p == 42) return mk(OP_SUB, R_NB, R_ZERO, R_B);
    if (p < PC_ROOT1) return root_u(p - PC_ROOT0, 1'b0);
    if (p < PC_PLANES) return root_u(p - PC_ROOT1, 1'b1);
    if (p == PC_PLANES) return mk(OP_BMAGLE, R_ZERO, R_DZ, R_TOL, PC_END);
    if (p < PC_PLANE1) return plane_u(p - PC_PLANE0, 1'b0);
    if (p < PC_END) return plane_u(p - PC_PLANE1, 1'b1);
    return mk(OP_END, R_ZERO, R_ZERO, R_ZERO);
  endfunction

endpackage

/* design/rcei_front.sv */
// Front end: accepts rays and queues them for the sequencer.
module rcei_front import rcei_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  input  logic pop_i,
  output logic avail_o,
  output req_t ray_o
);

  req_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign avail_o    = (cnt_q != 2'd0);
  assign ray_o      = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= in_req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

endmodule

/* design/rcei_arith.sv */
// Shared multi-cycle unit: rounded multiply, rounded divide, square root.
module rcei_arith import rcei_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  ar_e  op_i,
  input  fx_t  a_i,
  input  fx_t  b_i,
  output logic done_o,
  output fx_t  res_o
);

  typedef enum logic [2:0] {
    AS_IDLE, AS_MUL, AS_MULFIN, AS_DIV, AS_DIVFIN, AS_SQRT, AS_SQRTFIN, AS_DONE
  } ar_state_e;

  ar_state_e      as_q, as_d;
  logic [5:0]     cnt_q;
  logic           neg_q;
  logic [63:0]    ua_q, ub_q, prod_q, lo_q, q_q, d_q;
  logic [1:0]     psh_q;
  logic [127:0]   acc_q, addend, rnd;
  logic [64:0]    r_q, r2;
  logic [95:0]    x_q;
  logic [51:0]    rem_q, rem2, trial;
  logic [48:0]    root_q;
  fx_t            res_q;
  logic [63:0]    ua_in, ub_in;
  logic           neg_in, div_zero, div_ovf;
  logic [31:0]    pa, pb;

  assign ua_in    = fmag(a_i);
  assign ub_in    = fmag(b_i);
  assign neg_in   = a_i[63] ^ b_i[63];
  assign div_zero = (ua_in == 64'd0);
  assign div_ovf  = (ub_in == 64'd0) || ({32'd0, ua_in[63:32]} >= ub_in);
  assign done_o   = (as_q == AS_DONE);
  assign res_o    = res_q;

  always_comb begin
    pa = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
    pb = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
    case (psh_q)
      2'd0:    addend = {64'd0, prod_q};
      2'd1:    addend = {32'd0, prod_q, 32'd0};
      default: addend = {prod_q, 64'd0};
    endcase
    rnd   = acc_q + 128'h8000_0000;
    r2    = {r_q[63:0], lo_q[63]};
    rem2  = {rem_q[49:0], x_q[95:94]};
    trial = {1'b0, root_q, 2'b01};
  end

  always_comb begin
    as_d = as_q;
    case (as_q)
      AS_IDLE: begin
        if (start_i) begin
          case (op_i)
            AR_MUL:  as_d = AS_MUL;
            AR_DIV:  as_d = (div_zero || div_ovf) ? AS_DONE : AS_DIV;
            default: as_d = (a_i <= 0) ? AS_DONE : AS_SQRT;
          endcase
        end
      end
      AS_MUL:     if (cnt_q == 6'd4) as_d = AS_MULFIN;
      AS_MULFIN:  as_d = AS_DONE;
      AS_DIV:     if (cnt_q == 6'd63) as_d = AS_DIVFIN;
      AS_DIVFIN:  as_d = AS_DONE;
      AS_SQRT:    if (cnt_q == 6'd47) as_d = AS_SQRTFIN;
      AS_SQRTFIN: as_d = AS_DONE;
      default:    as_d = AS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      as_q  <= AS_IDLE;
      cnt_q <= 6'd0;
    end else begin
      as_q  <= as_d;
      cnt_q <= (as_q == AS_IDLE) ? 6'd0 : cnt_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (as_q)
      AS_IDLE: begin
        if (start_i) begin
          neg_q <= neg_in;
          case (op_i)
            AR_MUL: begin
              ua_q  <= ua_in;
              ub_q  <= ub_in;
              acc_q <= '0;
            end
            AR_DIV: begin
              if (div_zero) res_q <= FX_ZERO;
              else          res_q <= from_mag(neg_in, '1);
              r_q  <= {33'd0, ua_in[63:32]};
              lo_q <= {ua_in[31:0], 32'd0};
              q_q  <= '0;
              d_q  <= ub_in;
            end
            default: begin
              res_q  <= FX_ZERO;
              x_q    <= {a_i, 32'd0};
              rem_q  <= '0;
              root_q <= '0;
            end
          endcase
        end
      end
      AS_MUL: begin
        if (cnt_q < 6'd4) begin
          prod_q <= pa * pb;
          psh_q  <= {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
        end
        if (cnt_q != 6'd0) acc_q <= acc_q + addend;
      end
      AS_MULFIN: begin
        if (rnd[127:95] != '0) res_q <= from_mag(neg_q, '1);
        else                   res_q <= from_mag(neg_q, rnd[95:32]);
      end
      AS_DIV: begin
        lo_q <= {lo_q[62:0], 1'b0};
        if (r2 >= {1'b0, d_q}) begin
          r_q <= r2 - {1'b0, d_q};
          q_q <= {q_q[62:0], 1'b1};
        end else begin
          r_q <= r2;
          q_q <= {q_q[62:0], 1'b0};
        end
      end
      AS_DIVFIN: begin
        if (r_q[63:0] >= d_q - r_q[63:0]) begin
          if (q_q == '1) res_q <= from_mag(neg_q, '1);
          else           res_q <= from_mag(neg_q, q_q + 64'd1);
        end else begin
          res_q <= from_mag(neg_q, q_q);
        end
      end
      AS_SQRT: begin
        x_q <= {x_q[93:0], 2'b00};
        if (rem2 >= trial) begin
          rem_q  <= rem2 - trial;
          root_q <= {root_q[47:0], 1'b1};
        end else begin
          rem_q  <= rem2;
          root_q <= {root_q[47:0], 1'b0};
        end
      end
      AS_SQRTFIN: begin
        res_q <= {15'd0, root_q} + ((rem_q > {3'd0, root_q}) ? 64'sd1 : 64'sd0);
      end
      default: ;
    endcase
  end

endmodule

/* design/rcei_core.sv */
// Back end: sequencer with register file that runs one ray's program.
module rcei_core import rcei_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    avail_i,
  input  req_t    ray_i,
  output logic    pop_o,
  output logic    hs_valid_o,
  input  logic    hs_ready_i,
  output hitset_t hs_o
);

  typedef enum logic [2:0] {C_IDLE, C_READ, C_EXEC, C_WAIT, C_DONE} core_state_e;

  core_state_e         st_q, st_d;
  logic [PC_W-1:0]     pc_q, pc_d;
  req_t                ray_q;
  uop_t                uop;
  fx_t                 in_v [16];
  fx_t                 rf_mem [RF_DEPTH];
  fx_t                 opa_q, opb_q;
  fx_t                 wr_data, ar_res;
  logic                wr_en, ar_start, ar_done;
  ar_e                 ar_op;
  logic                flag_q, flag_d, ent_q, ent_d, rec;
  hit_t [MAX_HITS-1:0] hit_q;
  logic [2:0]          hn_q;
  fx_t                 sh_t_q, sh_x_q, sh_y_q, sh_z_q;
  fx_t                 az, zlo_raw, zhi_raw;

  assign uop        = rcei_rom(pc_q);
  assign hs_o.h     = hit_q;
  assign hs_o.n     = hn_q;
  assign hs_valid_o = (st_q == C_DONE);

  always_comb begin
    az      = axis_of(cfg_i.az);
    zlo_raw = sx32(cfg_i.zlo);
    zhi_raw = sx32(cfg_i.zhi);
    in_v[0]  = FX_ZERO;
    in_v[1]  = FX_ONE;
    in_v[2]  = tol_fx(cfg_i.tol);
    in_v[3]  = axis_of(cfg_i.ax);
    in_v[4]  = axis_of(cfg_i.ay);
    in_v[5]  = az;
    in_v[6]  = (zlo_raw < -az) ? -az : ((zlo_raw > az) ? az : zlo_raw);
    in_v[7]  = (zhi_raw < -az) ? -az : ((zhi_raw > az) ? az : zhi_raw);
    in_v[8]  = sx32(ray_q.origin_x);
    in_v[9]  = sx32(ray_q.origin_y);
    in_v[10] = sx32(ray_q.origin_z);
    in_v[11] = sx32(ray_q.dir_x);
    in_v[12] = sx32(ray_q.dir_y);
    in_v[13] = sx32(ray_q.dir_z);
    in_v[14] = FX_ONE + tol_fx(cfg_i.tol);
    in_v[15] = FX_ZERO;
  end

  always_comb begin
    case (uop.op)
      OP_MUL:  ar_op = AR_MUL;
      OP_DIV:  ar_op = AR_DIV;
      default: ar_op = AR_SQRT;
    endcase
  end

  rcei_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ar_start),
    .op_i    (ar_op),
    .a_i     (opa_q),
    .b_i     (opb_q),
    .done_o  (ar_done),
    .res_o   (ar_res)
  );

  always_comb begin
    st_d     = st_q;
    pc_d     = pc_q;
    wr_en    = 1'b0;
    wr_data  = sadd(opa_q, opb_q);
    ar_start = 1'b0;
    flag_d   = flag_q;
    ent_d    = ent_q;
    rec      = 1'b0;
    pop_o    = 1'b0;
    case (st_q)
      C_IDLE: begin
        if (avail_i) begin
          pop_o = 1'b1;
          pc_d  = '0;
          st_d  = C_READ;
        end
      end
      C_READ: st_d = C_EXEC;
      C_EXEC: begin
        pc_d = pc_q + 1'b1;
        st_d = C_READ;
        case (uop.op)
          OP_ADD: wr_en = 1'b1;
          OP_SUB: begin
            wr_en   = 1'b1;
            wr_data = ssub(opa_q, opb_q);
          end
          OP_SNAP: begin
            wr_en   = 1'b1;
            wr_data = (opa_q > 0 && opa_q < opb_q) ? FX_ZERO : opa_q;
          end
          OP_MUL, OP_DIV, OP_SQRT: begin
            ar_start = 1'b1;
            pc_d     = pc_q;
            st_d     = C_WAIT;
          end
          OP_BLE:    if (opa_q <= opb_q) pc_d = uop.tgt;
          OP_BLT:    if (opa_q < opb_q) pc_d = uop.tgt;
          OP_BMAGLE: if (fmag(opa_q) <= opb_q) pc_d = uop.tgt;
          OP_SETGE:  flag_d = (opa_q >= opb_q);
          OP_ANDLE:  flag_d = flag_q && (opa_q <= opb_q);
          OP_SETLE:  flag_d = (opa_q <= opb_q);
          OP_SETLT:  ent_d = (opa_q < opb_q);
          OP_REC:    rec = flag_q && (hn_q < 3'(MAX_HITS));
          default: begin
            pc_d = pc_q;
            st_d = C_DONE;
          end
        endcase
      end
      C_WAIT: begin
        if (ar_done) begin
          wr_en   = 1'b1;
          wr_data = ar_res;
          pc_d    = pc_q + 1'b1;
          st_d    = C_READ;
        end
      end
      default: if (hs_ready_i) st_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= C_IDLE;
      pc_q   <= '0;
      flag_q <= 1'b0;
      ent_q  <= 1'b0;
      hn_q   <= '0;
    end else begin
      st_q   <= st_d;
      pc_q   <= pc_d;
      flag_q <= flag_d;
      ent_q  <= ent_d;
      if (pop_o) hn_q <= '0;
      else if (rec) hn_q <= hn_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) ray_q <= ray_i;
    if (st_q == C_READ) begin
      opa_q <= (uop.a < R_MEM0) ? in_v[uop.a[3:0]] : rf_mem[uop.a];
      opb_q <= (uop.b < R_MEM0) ? in_v[uop.b[3:0]] : rf_mem[uop.b];
    end
    if (wr_en) rf_mem[uop.dst] <= wr_data;
    // mirror the hit operands so a record takes them all together
    if (wr_en && uop.dst == R_T) sh_t_q <= wr_data;
    if (wr_en && uop.dst == R_PT0) sh_x_q <= wr_data;
    if (wr_en && uop.dst == R_PT0 + 6'd1) sh_y_q <= wr_data;
    if (wr_en && uop.dst == R_PT2) sh_z_q <= wr_data;
    if (rec) begin
      hit_q[hn_q[1:0]] <= '{t: sh_t_q, x: sh_x_q, y: sh_y_q, z: sh_z_q, ent: ent_q};
    end
  end

endmodule

/* design/rcei_sorter.sv */
// Result stage: sorts hits by distance, drops near duplicates, emits them.
module rcei_sorter import rcei_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] tol_i,
  input  logic        hs_valid_i,
  output logic        hs_ready_o,
  input  hitset_t     hs_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output res_t        out_res_o
);

  typedef enum logic [1:0] {SO_IDLE, SO_SORT, SO_EMIT} sort_state_e;

  sort_state_e         so_q, so_d;
  hitset_t             hs_q;
  logic [MAX_HITS-1:0] used_q;
  logic [2:0]          scnt_q, kcnt_q;
  logic [1:0]          e_q;
  fx_t                 last_q;
  res_t                kept_q [MAX_HITS];
  logic [1:0]          best;
  logic                found, drop, load, emit;
  logic signed [64:0]  diff;
  hit_t                pick;

  assign hs_ready_o  = (so_q == SO_IDLE);
  assign load        = hs_valid_i && hs_ready_o;
  assign out_valid_o = (so_q == SO_EMIT);
  assign emit        = out_valid_o && !out_stall_i;

  always_comb begin
    out_res_o          = kept_q[e_q];
    out_res_o.last_hit = ({1'b0, e_q} == kcnt_q - 3'd1);
  end

  // stable minimum: lowest index wins on equal distance
  always_comb begin
    best  = '0;
    found = 1'b0;
    for (int i = 0; i < MAX_HITS; i++) begin
      if (3'(i) < hs_q.n && !used_q[i] && (!found || hs_q.h[i].t < hs_q.h[best].t)) begin
        best  = 2'(i);
        found = 1'b1;
      end
    end
    pick = hs_q.h[best];
    diff = {pick.t[63], pick.t} - {last_q[63], last_q};
    drop = (kcnt_q != 3'd0) && (diff < $signed({1'b0, tol_fx(tol_i)}));
  end

  always_comb begin
    so_d = so_q;
    case (so_q)
      SO_IDLE: if (load && hs_i.n != 3'd0) so_d = SO_SORT;
      SO_SORT: if (scnt_q == hs_q.n - 3'd1) so_d = SO_EMIT;
      SO_EMIT: if (emit && ({1'b0, e_q} == kcnt_q - 3'd1)) so_d = SO_IDLE;
      default: so_d = SO_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      so_q   <= SO_IDLE;
      used_q <= '0;
      scnt_q <= '0;
      kcnt_q <= '0;
      e_q    <= '0;
    end else begin
      so_q <= so_d;
      if (load) begin
        used_q <= '0;
        scnt_q <= '0;
        kcnt_q <= '0;
        e_q    <= '0;
      end else if (so_q == SO_SORT) begin
        used_q[best] <= 1'b1;
        scnt_q       <= scnt_q + 3'd1;
        if (!drop) kcnt_q <= kcnt_q + 3'd1;
      end else if (emit) begin
        e_q <= e_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) hs_q <= hs_i;
    if (so_q == SO_SORT && !drop) begin
      last_q <= pick.t;
      kept_q[kcnt_q[1:0]] <= '{hit_distance: to_out(pick.t), hit_x: to_out(pick.x),
                               hit_y: to_out(pick.y), hit_z: to_out(pick.z),
                               entering: pick.ent, last_hit: 1'b0};
    end
  end

endmodule

/* design/ray_cut_ellipsoid_intersect.sv */
// Top level: configuration registers, ray queue, sequencer and result stage.
//
//   port group   dir  handshake              payload
//   in_*         in   in_valid_i/in_stall_o  req_t  (one ray)
//   out_*        out  out_valid_o/out_stall_i res_t (one hit, last_hit ends a ray)
//   cfg_*        in   cfg_valid_i/cfg_ready_o index 3 bit, data 32 bit
//
// A ray's time in the sequencer is set by the shared bit-serial divider
// (one quotient bit per cycle, up to 22 divisions a ray).
// Two rays queue ahead of the sequencer and one ray's hits wait in the result stage.
// Reset restores the default registers and empties queue and result stage.
// A stalled output holds its hit; the sequencer keeps working on the next ray.
module ray_cut_ellipsoid_intersect import rcei_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  req_t        in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output res_t        out_res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t    cfg_q;
  logic    avail, pop, hs_valid, hs_ready;
  req_t    ray;
  hitset_t hs;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ax  <= 31'd65536;
      cfg_q.ay  <= 31'd65536;
      cfg_q.az  <= 31'd65536;
      cfg_q.zlo <= -32'sd65536;
      cfg_q.zhi <= 32'sd65536;
      cfg_q.tol <= 16'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_AXIS_X:  cfg_q.ax  <= cfg_data_i[30:0];
        CFG_AXIS_Y:  cfg_q.ay  <= cfg_data_i[30:0];
        CFG_AXIS_Z:  cfg_q.az  <= cfg_data_i[30:0];
        CFG_LOWER_Z: cfg_q.zlo <= cfg_data_i;
        CFG_UPPER_Z: cfg_q.zhi <= cfg_data_i;
        CFG_TOL:     cfg_q.tol <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  rcei_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .pop_i      (pop),
    .avail_o    (avail),
    .ray_o      (ray)
  );

  rcei_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .avail_i    (avail),
    .ray_i      (ray),
    .pop_o      (pop),
    .hs_valid_o (hs_valid),
    .hs_ready_i (hs_ready),
    .hs_o       (hs)
  );

  rcei_sorter u_sorter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tol_i       (cfg_q.tol),
    .hs_valid_i  (hs_valid),
    .hs_ready_o  (hs_ready),
    .hs_i        (hs),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

endmodule
